/* src/lslf_pkg.sv */
// ----------------------------------------------------------------------------
// lslf_pkg: shared definitions for the least-squares line fit
// Widths, sizes of the sum snapshot, saturation limits and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lslf_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = 48;

  // Accumulator widths follow from the coordinate width and the point limit.
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int PTS_LOG = $clog2(MAX_POINTS);
  localparam int SUM_W   = COORD_BITS + PTS_LOG;
  localparam int SQ_W    = 2 * COORD_BITS + PTS_LOG;

  // Shared multiplier: a wide operand times one digit of the narrow operand.
  localparam int MUL_A_W   = SQ_W;
  localparam int MUL_B_W   = SUM_W;
  localparam int DIG_W     = 12;
  localparam int NDIG      = (MUL_B_W + DIG_W - 1) / DIG_W;
  localparam int BPAD_W    = NDIG * DIG_W;
  localparam int DIG_CNT_W = $clog2(NDIG + 1);
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  // Divider: magnitude shifted up by the fraction bits.
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int QCNT_W = $clog2(NUM_W + 1);
  localparam int QX_W   = ((NUM_W > OUT_W) ? NUM_W : OUT_W) + 1;

  localparam logic [QX_W-1:0] SAT_NEG_MAG = QX_W'(1) << (OUT_W - 1);
  localparam logic [QX_W-1:0] SAT_POS_MAG = SAT_NEG_MAG - QX_W'(1);

  // Snapshot queue between accumulator and solver.
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    FIT_OK       = 2'd0,
    FIT_ZERO_DEN = 2'd1,
    FIT_TOO_MANY = 2'd2
  } fit_status_t;

  typedef struct packed {
    logic             ovf;
    logic [CNT_W-1:0] n;
    logic [SUM_W-1:0] sx;
    logic [SQ_W-1:0]  sxx;
    logic [SUM_W-1:0] sy;
    logic [SQ_W-1:0]  sxy;
  } snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/lslf_front.sv */
// ----------------------------------------------------------------------------
// lslf_front: point accumulator
// Sums count, x, x*x, y and x*y one point per cycle while accept is high, and
// hands a snapshot of the sums to the queue on the last point of a set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lslf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [lslf_pkg::COORD_BITS-1:0]  x,
  input  logic [lslf_pkg::COORD_BITS-1:0]  y,
  input  logic                             last,
  output logic                             push,
  output lslf_pkg::snap_t                  push_data
);

  logic [lslf_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [lslf_pkg::SUM_W-1:0]        sx_r, sx_nxt, sy_r, sy_nxt;
  logic [lslf_pkg::SQ_W-1:0]         sxx_r, sxx_nxt, sxy_r, sxy_nxt;
  logic                              ovf_r, ovf_nxt;
  logic [2*lslf_pkg::COORD_BITS-1:0] xx, xy;
  logic                              at_limit;

  assign xx       = x * x;
  assign xy       = x * y;
  assign at_limit = (count_r == lslf_pkg::CNT_W'(lslf_pkg::MAX_POINTS));

  always_comb begin
    count_nxt = count_r;
    sx_nxt    = sx_r;
    sxx_nxt   = sxx_r;
    sy_nxt    = sy_r;
    sxy_nxt   = sxy_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (at_limit) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
        sx_nxt    = sx_r + lslf_pkg::SUM_W'(x);
        sxx_nxt   = sxx_r + lslf_pkg::SQ_W'(xx);
        sy_nxt    = sy_r + lslf_pkg::SUM_W'(y);
        sxy_nxt   = sxy_r + lslf_pkg::SQ_W'(xy);
      end
    end
    push_data.ovf = ovf_nxt;
    push_data.n   = count_nxt;
    push_data.sx  = sx_nxt;
    push_data.sxx = sxx_nxt;
    push_data.sy  = sy_nxt;
    push_data.sxy = sxy_nxt;
    push          = accept & last;
    // The set is closed: start the next one from empty sums.
    if (push) begin
      count_nxt = '0;
      sx_nxt    = '0;
      sxx_nxt   = '0;
      sy_nxt    = '0;
      sxy_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sx_r    <= '0;
      sxx_r   <= '0;
      sy_r    <= '0;
      sxy_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sx_r    <= sx_nxt;
      sxx_r   <= sxx_nxt;
      sy_r    <= sy_nxt;
      sxy_r   <= sxy_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

/* src/lslf_queue.sv */
// ----------------------------------------------------------------------------
// lslf_queue: short snapshot queue
// Holds closed sets between the accumulator and the solver; the head stays
// readable until the solver pops it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lslf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lslf_pkg::snap_t   push_data,
  input  logic              pop,
  output lslf_pkg::snap_t   head,
  output lslf_pkg::q_stat_t stat
);

  lslf_pkg::snap_t              mem_r [lslf_pkg::Q_DEPTH];
  logic [lslf_pkg::QP_W-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [lslf_pkg::QC_W-1:0]    cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign stat.full  = (cnt_r == lslf_pkg::QC_W'(lslf_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == lslf_pkg::QP_W'(lslf_pkg::Q_DEPTH - 1)) ? '0
                                                                      : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == lslf_pkg::QP_W'(lslf_pkg::Q_DEPTH - 1)) ? '0
                                                                      : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/lslf_div.sv */
// ----------------------------------------------------------------------------
// lslf_div: restoring divider
// Divides a magnitude shifted up by the fraction bits by the denominator,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lslf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lslf_pkg::PROD_W-1:0]   mag,
  input  logic [lslf_pkg::PROD_W-1:0]   den,
  output logic                          done,
  output logic [lslf_pkg::NUM_W-1:0]    quo
);

  logic [lslf_pkg::NUM_W-1:0]  num_r, num_nxt, q_r, q_nxt;
  logic [lslf_pkg::PROD_W-1:0] rem_r, rem_nxt;
  logic [lslf_pkg::PROD_W:0]   trial;
  logic [lslf_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt, done_r, done_nxt;
  logic                        ge;

  assign trial = {rem_r, num_r[lslf_pkg::NUM_W-1]};
  assign ge    = (trial >= {1'b0, den});
  assign done  = done_r;
  assign quo   = q_r;

  always_comb begin
    num_nxt  = num_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = {mag, {lslf_pkg::FRAC_BITS{1'b0}}};
      q_nxt    = '0;
      rem_nxt  = '0;
      cnt_nxt  = lslf_pkg::QCNT_W'(lslf_pkg::NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The remainder stays below the denominator, so it fits after the step.
      rem_nxt = ge ? lslf_pkg::PROD_W'(trial - {1'b0, den})
                   : trial[lslf_pkg::PROD_W-1:0];
      q_nxt   = {q_r[lslf_pkg::NUM_W-2:0], ge};
      num_nxt = num_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == lslf_pkg::QCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

endmodule

/* src/lslf_back.sv */
// ----------------------------------------------------------------------------
// lslf_back: line solver
// Forms the six sum products on a shared digit multiplier, then the two
// quotients on the divider (skipped on ovf or zero den); one result beat per set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lslf_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lslf_pkg::snap_t                head,
  input  lslf_pkg::q_stat_t              qstat,
  output logic                           pop,
  output logic                           out_strobe,
  output logic [lslf_pkg::OUT_W-1:0]     out_slope,
  output logic [lslf_pkg::OUT_W-1:0]     out_intercept,
  output logic [1:0]                     out_fit_status
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_DIV_S = 4'b0100,
    ST_DIV_I = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    OP_N_SXX   = 3'd0,
    OP_SX_SX   = 3'd1,
    OP_N_SXY   = 3'd2,
    OP_SX_SY   = 3'd3,
    OP_SY_SXX  = 3'd4,
    OP_SX_SXY  = 3'd5
  } op_t;

  state_t                          state_r, state_nxt;
  op_t                             op_r, op_nxt;
  logic [lslf_pkg::DIG_CNT_W-1:0]  dig_r, dig_nxt;
  logic [lslf_pkg::PROD_W-1:0]     acc_r, acc_nxt, t_r, t_nxt, den_r, den_nxt;
  logic [lslf_pkg::PROD_W-1:0]     smag_r, smag_nxt, imag_r, imag_nxt;
  logic                            sneg_r, sneg_nxt, ineg_r, ineg_nxt;
  logic [lslf_pkg::BPAD_W-1:0]     b_r, b_nxt;
  logic [lslf_pkg::OUT_W-1:0]      slope_r, slope_nxt;
  logic [lslf_pkg::OUT_W-1:0]      oslope_r, oslope_nxt, oint_r, oint_nxt;
  logic [1:0]                      ostat_r, ostat_nxt;
  logic                            ostb_r, ostb_nxt, dstart_r, dstart_nxt;
  logic [lslf_pkg::MUL_A_W-1:0]    a_sel;
  logic [lslf_pkg::MUL_A_W+lslf_pkg::DIG_W-1:0] mprod;
  logic                            diff_neg;
  logic [lslf_pkg::PROD_W-1:0]     diff_mag;
  logic                            div_done;
  logic [lslf_pkg::NUM_W-1:0]      div_quo;
  logic [lslf_pkg::PROD_W-1:0]     div_mag;

  function automatic logic [lslf_pkg::MUL_A_W-1:0] a_of(input op_t op,
                                                       input lslf_pkg::snap_t s);
    case (op)
      OP_N_SXX:  a_of = s.sxx;
      OP_SX_SX:  a_of = lslf_pkg::MUL_A_W'(s.sx);
      OP_N_SXY:  a_of = s.sxy;
      OP_SX_SY:  a_of = lslf_pkg::MUL_A_W'(s.sy);
      OP_SY_SXX: a_of = s.sxx;
      OP_SX_SXY: a_of = s.sxy;
      default:   a_of = '0;
    endcase
  endfunction

  function automatic logic [lslf_pkg::BPAD_W-1:0] b_of(input op_t op,
                                                      input lslf_pkg::snap_t s);
    case (op)
      OP_N_SXX:  b_of = lslf_pkg::BPAD_W'(s.n);
      OP_SX_SX:  b_of = lslf_pkg::BPAD_W'(s.sx);
      OP_N_SXY:  b_of = lslf_pkg::BPAD_W'(s.n);
      OP_SX_SY:  b_of = lslf_pkg::BPAD_W'(s.sx);
      OP_SY_SXX: b_of = lslf_pkg::BPAD_W'(s.sy);
      OP_SX_SXY: b_of = lslf_pkg::BPAD_W'(s.sx);
      default:   b_of = '0;
    endcase
  endfunction

  // Signed result from a quotient magnitude, clamped to the output range.
  function automatic logic [lslf_pkg::OUT_W-1:0] sat_q(input logic [lslf_pkg::NUM_W-1:0] q,
                                                      input logic neg);
    logic [lslf_pkg::QX_W-1:0] qx;
    logic [lslf_pkg::QX_W-1:0] nq;
    qx = lslf_pkg::QX_W'(q);
    nq = lslf_pkg::QX_W'(0) - qx;
    if (neg) begin
      sat_q = (qx > lslf_pkg::SAT_NEG_MAG) ? lslf_pkg::SAT_NEG_MAG[lslf_pkg::OUT_W-1:0]
                                           : nq[lslf_pkg::OUT_W-1:0];
    end else begin
      sat_q = (qx > lslf_pkg::SAT_POS_MAG) ? lslf_pkg::SAT_POS_MAG[lslf_pkg::OUT_W-1:0]
                                           : qx[lslf_pkg::OUT_W-1:0];
    end
  endfunction

  assign a_sel    = a_of(op_r, head);
  assign mprod    = a_sel * b_r[lslf_pkg::BPAD_W-1 -: lslf_pkg::DIG_W];
  assign diff_neg = (t_r < acc_r);
  assign diff_mag = diff_neg ? (acc_r - t_r) : (t_r - acc_r);
  assign div_mag  = (state_r == ST_DIV_I) ? imag_r : smag_r;

  lslf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dstart_r),
    .mag   (div_mag),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    dig_nxt    = dig_r;
    acc_nxt    = acc_r;
    t_nxt      = t_r;
    den_nxt    = den_r;
    smag_nxt   = smag_r;
    sneg_nxt   = sneg_r;
    imag_nxt   = imag_r;
    ineg_nxt   = ineg_r;
    b_nxt      = b_r;
    slope_nxt  = slope_r;
    oslope_nxt = oslope_r;
    oint_nxt   = oint_r;
    ostat_nxt  = ostat_r;
    ostb_nxt   = 1'b0;
    dstart_nxt = 1'b0;
    pop        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          state_nxt = ST_MUL;
          op_nxt    = OP_N_SXX;
          dig_nxt   = '0;
          acc_nxt   = '0;
          b_nxt     = b_of(OP_N_SXX, head);
        end
      end
      ST_MUL: begin
        if (dig_r != lslf_pkg::DIG_CNT_W'(lslf_pkg::NDIG)) begin
          // Most significant digit first: shift the partial sum up a digit.
          acc_nxt = (acc_r << lslf_pkg::DIG_W) + lslf_pkg::PROD_W'(mprod);
          b_nxt   = b_r << lslf_pkg::DIG_W;
          dig_nxt = dig_r + 1'b1;
        end else begin
          dig_nxt = '0;
          acc_nxt = '0;
          op_nxt  = op_t'(op_r + 3'd1);
          b_nxt   = b_of(op_t'(op_r + 3'd1), head);
          case (op_r)
            OP_SX_SX: begin
              den_nxt = t_r - acc_r;
            end
            OP_SX_SY: begin
              smag_nxt = diff_mag;
              sneg_nxt = diff_neg;
            end
            OP_SX_SXY: begin
              imag_nxt = diff_mag;
              ineg_nxt = diff_neg;
              if (head.ovf) begin
                ostat_nxt  = lslf_pkg::FIT_TOO_MANY;
                oslope_nxt = '0;
                oint_nxt   = '0;
                ostb_nxt   = 1'b1;
                pop        = 1'b1;
                state_nxt  = ST_IDLE;
              end else if (den_r == '0) begin
                ostat_nxt  = lslf_pkg::FIT_ZERO_DEN;
                oslope_nxt = '0;
                oint_nxt   = '0;
                ostb_nxt   = 1'b1;
                pop        = 1'b1;
                state_nxt  = ST_IDLE;
              end else begin
                dstart_nxt = 1'b1;
                state_nxt  = ST_DIV_S;
              end
            end
            default: begin
              t_nxt = acc_r;
            end
          endcase
        end
      end
      ST_DIV_S: begin
        if (div_done) begin
          slope_nxt  = sat_q(div_quo, sneg_r);
          dstart_nxt = 1'b1;
          state_nxt  = ST_DIV_I;
        end
      end
      ST_DIV_I: begin
        if (div_done) begin
          oslope_nxt = slope_r;
          oint_nxt   = sat_q(div_quo, ineg_r);
          ostat_nxt  = lslf_pkg::FIT_OK;
          ostb_nxt   = 1'b1;
          pop        = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      op_r     <= OP_N_SXX;
      dig_r    <= '0;
      ostb_r   <= 1'b0;
      dstart_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      dig_r    <= dig_nxt;
      ostb_r   <= ostb_nxt;
      dstart_r <= dstart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    t_r      <= t_nxt;
    den_r    <= den_nxt;
    smag_r   <= smag_nxt;
    sneg_r   <= sneg_nxt;
    imag_r   <= imag_nxt;
    ineg_r   <= ineg_nxt;
    b_r      <= b_nxt;
    slope_r  <= slope_nxt;
    oslope_r <= oslope_nxt;
    oint_r   <= oint_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign out_strobe     = ostb_r;
  assign out_slope      = oslope_r;
  assign out_intercept  = oint_r;
  assign out_fit_status = ostat_r;

endmodule

/* src/least_squares_line_fit.sv */
// ----------------------------------------------------------------------------
// least_squares_line_fit: streaming least-squares line fit
// Accumulates integer points and, on the last point of a set, returns the
// fitted slope and intercept in signed fixed point with a status code.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Beat contents
//   -------   ---------  ---------------------  ----------------------------------
//   input     in         start & !busy          in_x_coord, in_y_coord,
//                                               in_last_point
//   result    out        out_strobe (1 cycle)   out_slope, out_intercept,
//                                               out_fit_status
//
// Points are taken one per cycle while busy is low. The last point of a set
// closes it: its sums go into a two-entry queue and the accumulator starts over
// in the same cycle, so the next set streams in while the solver works.
// The solver uses the shared digit multiplier and then the bit-serial divider;
// the divider dominates. busy rises only while the queue holds two closed sets,
// one in the solver and one waiting behind it. Synchronous reset clears the
// sums, the queue and the solver. The result beat is shown for one cycle and
// cannot be held off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module least_squares_line_fit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [lslf_pkg::COORD_BITS-1:0]        in_x_coord,
  input  logic [lslf_pkg::COORD_BITS-1:0]        in_y_coord,
  input  logic                                   in_last_point,
  output logic                                   out_strobe,
  output logic signed [lslf_pkg::OUT_W-1:0]      out_slope,
  output logic signed [lslf_pkg::OUT_W-1:0]      out_intercept,
  output logic [1:0]                             out_fit_status
);

  logic                           accept;
  logic                           push;
  lslf_pkg::snap_t                push_data;
  lslf_pkg::snap_t                head;
  lslf_pkg::q_stat_t              qstat;
  logic                           pop;
  logic [lslf_pkg::OUT_W-1:0]     slope_u;
  logic [lslf_pkg::OUT_W-1:0]     intercept_u;

  // Any point needs a free queue slot in case it turns out to close the set.
  assign busy   = qstat.full;
  assign accept = start & ~busy;

  lslf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .x         (in_x_coord),
    .y         (in_y_coord),
    .last      (in_last_point),
    .push      (push),
    .push_data (push_data)
  );

  lslf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  // The solver reads the queue head in place and pops it with the result beat.
  lslf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .qstat          (qstat),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_slope      (slope_u),
    .out_intercept  (intercept_u),
    .out_fit_status (out_fit_status)
  );

  assign out_slope     = $signed(slope_u);
  assign out_intercept = $signed(intercept_u);

endmodule

/* src/lslf_checker.sv */
// ----------------------------------------------------------------------------
// lslf_checker: port-level checks for the line fit
// Watches the top-level ports and flags result beats that break the block's
// timing or coding rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lslf_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 busy,
  input logic                                 out_strobe,
  input logic signed [lslf_pkg::OUT_W-1:0]    out_slope,
  input logic signed [lslf_pkg::OUT_W-1:0]    out_intercept,
  input logic [1:0]                           out_fit_status
);

  // Each set passes through all six products in the solver, so result beats never abut.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result beats in consecutive cycles");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_fit_status == lslf_pkg::FIT_OK ||
                    out_fit_status == lslf_pkg::FIT_ZERO_DEN ||
                    out_fit_status == lslf_pkg::FIT_TOO_MANY))
    else $error("undefined fit status");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_fit_status != lslf_pkg::FIT_OK) |->
      (out_slope == '0 && out_intercept == '0))
    else $error("nonzero line on a failed fit");

  // Reset empties the queue and the solver.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("busy or result right after reset");

endmodule

bind least_squares_line_fit lslf_checker u_lslf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_slope      (out_slope),
  .out_intercept  (out_intercept),
  .out_fit_status (out_fit_status)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for least_squares_line_fit
// Streams point sets into the fitter and predicts each fitted line from the
// running sums. Every strobed result is compared with the oldest outstanding
// fit. Coverage comes from a short directed run and random sets with gaps on
// the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // The queue can hold two closed sets, so busy may stay high while the solver
  // works through one of them; the quiet-cycle limit is set well above that
  // wait plus the longest sender gap.
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 400;
  localparam int RANDOM_POINTS = 1000;
  localparam int CALM_FROM     = 850;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [127:0] NEG_MAG = 128'd1 << (lslf_pkg::OUT_W - 1);
  localparam logic [127:0] POS_MAG = NEG_MAG - 128'd1;

  typedef logic [lslf_pkg::COORD_BITS-1:0]   coord_t;
  typedef logic signed [lslf_pkg::OUT_W-1:0] fixed_t;

  typedef struct {
    fixed_t                slope;
    fixed_t                intercept;
    lslf_pkg::fit_status_t status;
  } line_fit_t;

  // Shapes of random point sets. Vertical sets share one x and must come back
  // with a zero denominator; narrow sets give small ones, zero when all x agree.
  typedef enum int {
    SCATTER,
    VERTICAL,
    CORNERS,
    NARROW,
    SLANTED
  } point_style_t;

  // Scoreboard: keeps its own copy of the running sums, works out the fitted
  // line when a set closes, and holds the fits that are still outstanding.
  class line_fit_checker;
    line_fit_t    awaited_fits[$];
    int           mismatches;
    logic [127:0] n_pts, sx, sxx, sy, sxy;
    bit           too_many;

    function new();
      mismatches = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      n_pts    = '0;
      sx       = '0;
      sxx      = '0;
      sy       = '0;
      sxy      = '0;
      too_many = 1'b0;
    endfunction

    // (p - q) scaled by the fraction bits and divided by den, truncated toward
    // zero and clamped to the signed output range.
    function fixed_t fixed_ratio(logic [127:0] p, logic [127:0] q, logic [127:0] den);
      logic [127:0] mag;
      logic [127:0] quo;
      logic [127:0] neg_quo;
      logic         negative;
      negative = p < q;
      mag      = negative ? q - p : p - q;
      quo      = (mag << lslf_pkg::FRAC_BITS) / den;
      if (negative) begin
        if (quo > NEG_MAG) quo = NEG_MAG;
        neg_quo = 128'd0 - quo;
        return neg_quo[lslf_pkg::OUT_W-1:0];
      end
      if (quo > POS_MAG) quo = POS_MAG;
      return quo[lslf_pkg::OUT_W-1:0];
    endfunction

    function void take_point(coord_t x, coord_t y, logic closes_set);
      line_fit_t    fit;
      logic [127:0] den;
      if (n_pts >= lslf_pkg::MAX_POINTS) begin
        too_many = 1'b1;
      end else begin
        n_pts += 128'd1;
        sx    += 128'(x);
        sxx   += 128'(x) * 128'(x);
        sy    += 128'(y);
        sxy   += 128'(x) * 128'(y);
      end
      if (!closes_set) return;
      den           = n_pts * sxx - sx * sx;
      fit.slope     = '0;
      fit.intercept = '0;
      if (too_many) begin
        fit.status = lslf_pkg::FIT_TOO_MANY;
      end else if (den == 0) begin
        fit.status = lslf_pkg::FIT_ZERO_DEN;
      end else begin
        fit.status    = lslf_pkg::FIT_OK;
        fit.slope     = fixed_ratio(n_pts * sxy, sx * sy, den);
        fit.intercept = fixed_ratio(sy * sxx, sx * sxy, den);
      end
      awaited_fits.insert(awaited_fits.size(), fit);
      clear_sums();
    endfunction

    function void check_fit(fixed_t slope, fixed_t intercept, logic [1:0] status);
      line_fit_t want;
      if (awaited_fits.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: result with no fit outstanding: slope %0d intercept %0d status %0d",
                   $realtime, slope, intercept, status);
        mismatches++;
        return;
      end
      want = awaited_fits.pop_front();
      if (slope !== want.slope || intercept !== want.intercept ||
          status !== 2'(want.status)) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: fit mismatch: slope %0d/%0d intercept %0d/%0d status %0d/%0d",
                   $realtime, want.slope, slope, want.intercept, intercept,
                   want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic   clk           = 1'b0;
  logic   rst_n         = 1'b0;
  logic   start         = 1'b0;
  coord_t in_x_coord    = '0;
  coord_t in_y_coord    = '0;
  logic   in_last_point = 1'b0;
  logic   busy;
  logic   out_strobe;
  fixed_t out_slope;
  fixed_t out_intercept;
  logic [1:0] out_fit_status;

  line_fit_checker fits = new();
  int quiet_cycles = 0;
  int random_points = 0;

  least_squares_line_fit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_last_point  (in_last_point),
    .out_strobe     (out_strobe),
    .out_slope      (out_slope),
    .out_intercept  (out_intercept),
    .out_fit_status (out_fit_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Monitor: everything is sampled at the rising edge, so the values seen are
  // the ones that were stable during the cycle that this edge closes. An input
  // beat counts when start is high and busy low; a result when the strobe is.
  // The same block keeps the watchdog, which ends the run if neither side
  // moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        fits.take_point(in_x_coord, in_y_coord, in_last_point);
      if (out_strobe)
        fits.check_fit(out_slope, out_intercept, out_fit_status);
      if ((start && !busy) || out_strobe)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Presents one point and returns at the edge that accepts it. The caller is
  // always at a rising edge, so start stays high from one beat to the next
  // without being dropped in between. A gap, when taken, lowers start at this
  // edge and raises it again at a later one.
  task automatic send_point(coord_t x, coord_t y, logic closes_set, bit may_idle);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start         <= 1'b1;
    in_x_coord    <= x;
    in_y_coord    <= y;
    in_last_point <= closes_set;
    do @(posedge clk); while (busy);
  endtask

  // Sends one whole set whose points follow the given shape; the last point
  // closes the set.
  task automatic send_set(int len, point_style_t style, bit may_idle);
    coord_t x;
    coord_t y;
    coord_t base_x;
    int     slope16;
    int     offset;
    int     level;
    int     i;
    base_x  = coord_t'($urandom);
    slope16 = int'($urandom_range(0, 128)) - 64;
    offset  = int'($urandom_range(0, 4095));
    for (i = 0; i < len; i++) begin
      x = coord_t'($urandom);
      y = coord_t'($urandom);
      case (style)
        VERTICAL: begin
          x = base_x;
        end
        CORNERS: begin
          x = $urandom_range(0, 1) ? '1 : '0;
          y = $urandom_range(0, 1) ? '1 : '0;
        end
        NARROW: begin
          x = base_x + coord_t'($urandom_range(0, 3));
        end
        SLANTED: begin
          // Points scattered a little around a random line, kept in range.
          level = offset + (slope16 * int'(x)) / 16 + int'($urandom_range(0, 64)) - 32;
          if (level < 0) level = 0;
          if (level > 4095) level = 4095;
          y = coord_t'(level);
        end
        default: begin
        end
      endcase
      send_point(x, y, i == len - 1, may_idle);
      random_points++;
    end
  endtask

  initial begin
    int           len;
    int           pick;
    bit           calm;
    point_style_t style;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets. A lone point has no line through it.
    send_point('1, '1, 1'b1, 1'b0);
    // The full diagonal: slope exactly one, intercept zero.
    send_point('0, '0, 1'b0, 1'b0);
    send_point('1, '1, 1'b1, 1'b0);
    // All points share the largest x: zero denominator despite varying y.
    send_point('1, '0, 1'b0, 1'b0);
    send_point('1, '1, 1'b0, 1'b0);
    send_point('1, 12'd17, 1'b1, 1'b0);
    // Steepest rising line at the far edge: huge negative intercept.
    send_point(12'd4094, '0, 1'b0, 1'b0);
    send_point('1, '1, 1'b1, 1'b0);
    // Steepest falling line at the far edge: huge positive intercept.
    send_point(12'd4094, '1, 1'b0, 1'b0);
    send_point('1, '0, 1'b1, 1'b0);
    // The falling diagonal.
    send_point('0, '1, 1'b0, 1'b0);
    send_point('1, '0, 1'b1, 1'b0);
    // A fit that is not exact, so truncation toward zero matters on both signs.
    send_point(12'd1, 12'd2, 1'b0, 1'b0);
    send_point(12'd3, 12'd7, 1'b0, 1'b0);
    send_point(12'd5, 12'd1, 1'b0, 1'b0);
    send_point(12'd2, 12'd2, 1'b1, 1'b0);
    // Alternating bit patterns on both coordinates.
    send_point(12'hAAA, 12'h555, 1'b0, 1'b0);
    send_point(12'h555, 12'hAAA, 1'b0, 1'b0);
    send_point(12'hFFF, 12'h000, 1'b1, 1'b0);

    // Random sets, mostly short so that the solver queue fills and busy shows
    // up, with a few longer ones. Some sets run without gaps, and the tail of
    // the run has none at all.
    random_points = 0;
    while (random_points < RANDOM_POINTS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        len = 1;
      else if (pick < 3)
        len = $urandom_range(11, 64);
      else
        len = $urandom_range(2, 10);
      style = point_style_t'($urandom_range(0, 4));
      calm  = (random_points >= CALM_FROM) || ($urandom_range(0, 3) == 0);
      send_set(len, style, !calm);
    end
    start <= 1'b0;

    // Wait for every outstanding fit, then a while longer for stray results.
    while (fits.awaited_fits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fits.mismatches == 0 && fits.awaited_fits.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
